/* sv/bog_pkg.sv */
// Shared constants, types and helpers for the broadcast offset generator.
`timescale 1ns / 1ps

package bog_pkg;

  // Shape and index geometry
  localparam int MAX_DIMS    = 4;
  localparam int EXT_W       = 16;
  localparam int IDX_W       = 32;
  localparam int RANK_W      = 3;
  localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CFG_W       = 64;
  localparam int ADDR_W      = 6;

  // Divider slicing: quotient bits retired per stage
  localparam int BITS_PER_STG = 4;
  localparam int DIV_STEPS    = IDX_W / BITS_PER_STG;
  localparam int DIV_STAGES   = MAX_DIMS * DIV_STEPS;

  // Register indexes
  localparam logic [2:0] REG_OUT_RANK   = 3'd0;
  localparam logic [2:0] REG_LEFT_RANK  = 3'd1;
  localparam logic [2:0] REG_RIGHT_RANK = 3'd2;
  localparam logic [2:0] REG_OUT_EXT    = 3'd3;
  localparam logic [2:0] REG_LEFT_EXT   = 3'd4;
  localparam logic [2:0] REG_RIGHT_EXT  = 3'd5;

  typedef logic [MAX_DIMS-1:0][EXT_W-1:0] coord_t;

  // Item state while it walks the divider stages
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] q;     // dividend shifting into quotient
    logic [EXT_W-1:0] rem;
    coord_t           coord;
    logic             zero;  // a live output extent is zero
  } div_t;

  // Item state while it walks the offset accumulation stages
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             ok;
    coord_t           coord;
    logic [IDX_W-1:0] lacc;
    logic [IDX_W-1:0] racc;
  } hrn_t;

  // Rank clipped to the supported dimension count
  function automatic logic [RANK_W-1:0] sat_rank(input logic [RANK_W-1:0] r);
    sat_rank = (r > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : r;
  endfunction

endpackage

/* sv/bog_div_stage.sv */
// One slice of the pipelined divider: retires BITS_PER_STG quotient bits per cycle while en is high.
`timescale 1ns / 1ps

module bog_div_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  bog_pkg::div_t             d_i,
  input  logic [bog_pkg::EXT_W-1:0] ext,
  input  logic                      act,
  input  logic                      zero_ext,
  input  logic                      first,
  input  logic                      last,
  input  logic [bog_pkg::DIM_W-1:0] dim,
  output bog_pkg::div_t             d_o
);

  bog_pkg::div_t                d_nxt;
  bog_pkg::div_t                d_r;
  logic [bog_pkg::IDX_W-1:0]    q;
  logic [bog_pkg::EXT_W-1:0]    rem;
  logic [bog_pkg::EXT_W:0]      rt;

  // restoring division steps
  always_comb begin
    d_nxt = d_i;
    q     = d_i.q;
    rem   = first ? '0 : d_i.rem;
    rt    = '0;
    if (act) begin
      for (int k = 0; k < bog_pkg::BITS_PER_STG; k++) begin
        rt = {rem, q[bog_pkg::IDX_W-1]};
        q  = {q[bog_pkg::IDX_W-2:0], 1'b0};
        if (rt >= {1'b0, ext}) begin
          rt   = rt - {1'b0, ext};
          q[0] = 1'b1;
        end
        rem = rt[bog_pkg::EXT_W-1:0];
      end
      d_nxt.q   = q;
      d_nxt.rem = rem;
      if (last) begin
        d_nxt.coord[dim] = rem;
      end
    end
    d_nxt.zero = d_i.zero | zero_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

/* sv/bog_hrn_stage.sv */
// One Horner step per operand: acc = acc * extent + coordinate.
`timescale 1ns / 1ps

module bog_hrn_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  bog_pkg::hrn_t             h_i,
  input  logic [bog_pkg::DIM_W-1:0] dim,
  input  logic [bog_pkg::EXT_W-1:0] l_ext,
  input  logic [bog_pkg::EXT_W-1:0] r_ext,
  input  logic                      l_use,
  input  logic                      r_use,
  output bog_pkg::hrn_t             h_o
);

  bog_pkg::hrn_t                           h_nxt;
  bog_pkg::hrn_t                           h_r;
  logic [bog_pkg::EXT_W-1:0]               lc;
  logic [bog_pkg::EXT_W-1:0]               rc;
  logic [bog_pkg::IDX_W+bog_pkg::EXT_W-1:0] lprod;
  logic [bog_pkg::IDX_W+bog_pkg::EXT_W-1:0] rprod;

  // broadcast dimensions of extent one read coordinate zero
  always_comb begin
    lc    = (l_ext == bog_pkg::EXT_W'(1)) ? '0 : h_i.coord[dim];
    rc    = (r_ext == bog_pkg::EXT_W'(1)) ? '0 : h_i.coord[dim];
    lprod = h_i.lacc * l_ext;
    rprod = h_i.racc * r_ext;
    h_nxt = h_i;
    if (l_use) begin
      h_nxt.lacc = lprod[bog_pkg::IDX_W-1:0] + bog_pkg::IDX_W'(lc);
    end
    if (r_use) begin
      h_nxt.racc = rprod[bog_pkg::IDX_W-1:0] + bog_pkg::IDX_W'(rc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r.vld <= 1'b0;
    end else if (en) begin
      h_r <= h_nxt;
    end
  end

  assign h_o = h_r;

endmodule

/* sv/broadcast_offset_generator_unit.sv */
// Pipeline: 32 divider stages, 4 offset stages, 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and stalled, so in_stall follows out_stall then.
// Each divider stage retires 4 quotient bits of one output dimension.
// Reset (synchronous, active low) empties the pipeline and sets all ranks
// and extent registers to 1.
`timescale 1ns / 1ps

module broadcast_offset_generator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bog_pkg::ADDR_W-1:0]  paddr,
  input  logic [bog_pkg::CFG_W-1:0]   pwdata,
  output logic [bog_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  // request in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bog_pkg::IDX_W-1:0]   in_flat_index,
  // result out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bog_pkg::IDX_W-1:0]   out_index_echo,
  output logic [bog_pkg::IDX_W-1:0]   out_left_offset,
  output logic [bog_pkg::IDX_W-1:0]   out_right_offset,
  output logic                        out_in_range
);

  logic [bog_pkg::RANK_W-1:0] out_rank_r, left_rank_r, right_rank_r;
  logic [bog_pkg::CFG_W-1:0]  out_ext_r, left_ext_r, right_ext_r;
  logic [bog_pkg::RANK_W-1:0] orank, lrank, rrank;
  logic [2:0]                 reg_sel;
  logic                       wr;
  logic                       en;

  bog_pkg::div_t              div_in;
  bog_pkg::div_t              div_s [bog_pkg::DIV_STAGES];
  bog_pkg::hrn_t              hrn_in;
  bog_pkg::hrn_t              hrn_s [bog_pkg::MAX_DIMS];
  bog_pkg::hrn_t              last_h;

  logic                       out_valid_r;
  logic [bog_pkg::IDX_W-1:0]  out_idx_r, out_loff_r, out_roff_r;
  logic                       out_ok_r;

  // config register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[bog_pkg::ADDR_W-1:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rank_r   <= bog_pkg::RANK_W'(1);
      left_rank_r  <= bog_pkg::RANK_W'(1);
      right_rank_r <= bog_pkg::RANK_W'(1);
      out_ext_r    <= bog_pkg::CFG_W'(1);
      left_ext_r   <= bog_pkg::CFG_W'(1);
      right_ext_r  <= bog_pkg::CFG_W'(1);
    end else if (wr) begin
      unique case (reg_sel)
        bog_pkg::REG_OUT_RANK:   out_rank_r   <= pwdata[bog_pkg::RANK_W-1:0];
        bog_pkg::REG_LEFT_RANK:  left_rank_r  <= pwdata[bog_pkg::RANK_W-1:0];
        bog_pkg::REG_RIGHT_RANK: right_rank_r <= pwdata[bog_pkg::RANK_W-1:0];
        bog_pkg::REG_OUT_EXT:    out_ext_r    <= pwdata;
        bog_pkg::REG_LEFT_EXT:   left_ext_r   <= pwdata;
        bog_pkg::REG_RIGHT_EXT:  right_ext_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bog_pkg::REG_OUT_RANK:   prdata = bog_pkg::CFG_W'(out_rank_r);
      bog_pkg::REG_LEFT_RANK:  prdata = bog_pkg::CFG_W'(left_rank_r);
      bog_pkg::REG_RIGHT_RANK: prdata = bog_pkg::CFG_W'(right_rank_r);
      bog_pkg::REG_OUT_EXT:    prdata = out_ext_r;
      bog_pkg::REG_LEFT_EXT:   prdata = left_ext_r;
      bog_pkg::REG_RIGHT_EXT:  prdata = right_ext_r;
      default:                 prdata = '0;
    endcase
  end

  assign orank = bog_pkg::sat_rank(out_rank_r);
  assign lrank = bog_pkg::sat_rank(left_rank_r);
  assign rrank = bog_pkg::sat_rank(right_rank_r);

  // global advance: hold everything while the result is stalled
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // divider entry
  always_comb begin
    div_in       = '0;
    div_in.vld   = in_valid;
    div_in.idx   = in_flat_index;
    div_in.q     = in_flat_index;
  end

  // divider chain: coordinate of each output dimension, innermost first
  for (genvar g = 0; g < bog_pkg::DIV_STAGES; g++) begin : g_div
    localparam int D = g / bog_pkg::DIV_STEPS;
    localparam int S = g % bog_pkg::DIV_STEPS;
    logic [bog_pkg::EXT_W-1:0] ext;
    logic                      live;
    assign ext  = out_ext_r[D*bog_pkg::EXT_W +: bog_pkg::EXT_W];
    assign live = bog_pkg::RANK_W'(D) < orank;
    bog_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .d_i      ((g == 0) ? div_in : div_s[(g == 0) ? 0 : g-1]),
      .ext      (ext),
      .act      (live && (ext != '0)),
      .zero_ext (live && (ext == '0)),
      .first    (S == 0),
      .last     (S == bog_pkg::DIV_STEPS-1),
      .dim      (bog_pkg::DIM_W'(D)),
      .d_o      (div_s[g])
    );
  end

  // in range when no live extent is zero and the final quotient is zero
  always_comb begin
    hrn_in       = '0;
    hrn_in.vld   = div_s[bog_pkg::DIV_STAGES-1].vld;
    hrn_in.idx   = div_s[bog_pkg::DIV_STAGES-1].idx;
    hrn_in.coord = div_s[bog_pkg::DIV_STAGES-1].coord;
    hrn_in.ok    = !div_s[bog_pkg::DIV_STAGES-1].zero &&
                   (div_s[bog_pkg::DIV_STAGES-1].q == '0);
  end

  // offset accumulation, outermost dimension first
  for (genvar s = 0; s < bog_pkg::MAX_DIMS; s++) begin : g_hrn
    localparam int J = bog_pkg::MAX_DIMS - 1 - s;
    bog_hrn_stage u_hrn (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .h_i   ((s == 0) ? hrn_in : hrn_s[(s == 0) ? 0 : s-1]),
      .dim   (bog_pkg::DIM_W'(J)),
      .l_ext (left_ext_r[J*bog_pkg::EXT_W +: bog_pkg::EXT_W]),
      .r_ext (right_ext_r[J*bog_pkg::EXT_W +: bog_pkg::EXT_W]),
      .l_use (bog_pkg::RANK_W'(J) < lrank),
      .r_use (bog_pkg::RANK_W'(J) < rrank),
      .h_o   (hrn_s[s])
    );
  end

  assign last_h = hrn_s[bog_pkg::MAX_DIMS-1];

  // output register; operands of higher rank than the output read offset 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last_h.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r  <= last_h.idx;
      out_ok_r   <= last_h.ok;
      out_loff_r <= (last_h.ok && (lrank <= orank)) ? last_h.lacc : '0;
      out_roff_r <= (last_h.ok && (rrank <= orank)) ? last_h.racc : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_index_echo   = out_idx_r;
  assign out_left_offset  = out_loff_r;
  assign out_right_offset = out_roff_r;
  assign out_in_range     = out_ok_r;

  // checks
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> (out_left_offset == '0) && (out_right_offset == '0))
    else $error("out of range result with nonzero offset");

  a_rst_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule
